// File: hw/rtl/skfu_pkg.sv
// shared types and constants for the scalar kalman update pipeline
// no dependencies, imported by every module of the block
`default_nettype none

package skfu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int NOISE_W   = 24;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int SUM_W     = VAL_W + 1;
    localparam int PV_W      = DIFF_W + GAIN_BITS + 1;
    localparam int PU_W      = VAL_W + GAIN_BITS + 1;
    localparam int NUM_STG   = GAIN_BITS + 3;

    localparam logic [NOISE_W-1:0] NOISE_RESET = NOISE_W'((1 << FRAC_BITS) / 100);
    localparam logic [GAIN_BITS:0] GAIN_ONE    = (GAIN_BITS+1)'(1 << GAIN_BITS);
    localparam logic [GAIN_BITS-1:0] GAIN_HALF = GAIN_BITS'(1 << (GAIN_BITS - 1));

    typedef struct packed {
        logic signed [VAL_W-1:0] prior_value;
        logic        [VAL_W-1:0] prior_uncertainty;
        logic signed [VAL_W-1:0] measured_value;
        logic        [VAL_W-1:0] measured_uncertainty;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_value;
        logic        [VAL_W-1:0] new_uncertainty;
        logic                    invalid;
    } t_out;

    // divider stage contents
    typedef struct packed {
        logic        [SUM_W-1:0]     rem;
        logic        [SUM_W-1:0]     dvs;
        logic        [GAIN_BITS-1:0] quo;
        logic        [VAL_W-1:0]     p;
        logic signed [DIFF_W-1:0]    d;
        logic signed [VAL_W-1:0]     prior_val;
        logic        [VAL_W-1:0]     prior_unc;
        logic                        invalid;
    } t_div;

    // multiplier stage contents
    typedef struct packed {
        logic signed [PV_W-1:0]  prod_v;
        logic        [PU_W-1:0]  prod_u;
        logic signed [VAL_W-1:0] prior_val;
        logic        [VAL_W-1:0] prior_unc;
        logic                    invalid;
    } t_mul;

endpackage

`default_nettype wire

// File: hw/rtl/skfu_front.sv
// front stage: noise add with saturation, divisor, innovation and zero check
// depends on skfu_pkg
`default_nettype none

module skfu_front
    import skfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire t_in                i_item,
    input  wire logic [NOISE_W-1:0] i_noise,
    output logic                    o_vld,
    output t_div                    o_d
);

    logic              r_vld;
    t_div              r_d;
    t_div              n_d;
    logic [SUM_W-1:0]  sum_p;
    logic [VAL_W-1:0]  p_sat;

    always_comb begin
        sum_p = {1'b0, i_item.prior_uncertainty} + SUM_W'(i_noise);
        p_sat = sum_p[SUM_W-1] ? '1 : sum_p[VAL_W-1:0];

        n_d.rem       = {1'b0, p_sat};
        n_d.dvs       = {1'b0, p_sat} + {1'b0, i_item.measured_uncertainty};
        n_d.quo       = '0;
        n_d.p         = p_sat;
        n_d.d         = $signed({i_item.measured_value[VAL_W-1], i_item.measured_value})
                      - $signed({i_item.prior_value[VAL_W-1], i_item.prior_value});
        n_d.prior_val = i_item.prior_value;
        n_d.prior_unc = i_item.prior_uncertainty;
        n_d.invalid   = (i_item.prior_uncertainty == '0)
                      || (i_item.measured_uncertainty == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/skfu_div_step.sv
// one restoring division step, one gain bit per stage
// depends on skfu_pkg
`default_nettype none

module skfu_div_step
    import skfu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_div i_d,
    output logic      o_vld,
    output t_div      o_d
);

    logic             r_vld;
    t_div             r_d;
    t_div             n_d;
    logic [SUM_W:0]   shifted;
    logic             ge;

    always_comb begin
        shifted = {i_d.rem, 1'b0};
        ge      = shifted >= {1'b0, i_d.dvs};
        n_d     = i_d;
        // remainder stays below the divisor so it fits again after the step
        n_d.rem = ge ? SUM_W'(shifted - {1'b0, i_d.dvs}) : shifted[SUM_W-1:0];
        n_d.quo = {i_d.quo[GAIN_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/skfu_mul.sv
// gain multiplications: gain times innovation and complement gain times variance
// depends on skfu_pkg
`default_nettype none

module skfu_mul
    import skfu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_div i_d,
    output logic      o_vld,
    output t_mul      o_d
);

    logic             r_vld;
    t_mul             r_d;
    t_mul             n_d;
    logic [GAIN_BITS:0] k_cmp;

    always_comb begin
        k_cmp         = GAIN_ONE - {1'b0, i_d.quo};
        n_d.prod_v    = PV_W'($signed({1'b0, i_d.quo})) * PV_W'(i_d.d);
        n_d.prod_u    = PU_W'(k_cmp) * PU_W'(i_d.p);
        n_d.prior_val = i_d.prior_val;
        n_d.prior_unc = i_d.prior_unc;
        n_d.invalid   = i_d.invalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/skfu_out.sv
// output stage: rounding, blend with saturation, bypass of invalid items
// depends on skfu_pkg
`default_nettype none

module skfu_out
    import skfu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_mul i_d,
    output logic      o_vld,
    output t_out      o_d
);

    localparam int DLT_W = PV_W - GAIN_BITS;
    localparam int NV_W  = DLT_W + 1;

    logic                    r_vld;
    t_out                    r_d;
    t_out                    n_d;
    logic signed [PV_W-1:0]  rnd_v;
    logic signed [DLT_W-1:0] delta;
    logic signed [NV_W-1:0]  nv;
    logic        [PU_W-1:0]  rnd_u;
    logic signed [VAL_W-1:0] nv_sat;

    always_comb begin
        rnd_v  = i_d.prod_v + PV_W'(GAIN_HALF);
        delta  = rnd_v[PV_W-1:GAIN_BITS];
        nv     = {{(NV_W-VAL_W){i_d.prior_val[VAL_W-1]}}, i_d.prior_val}
               + {delta[DLT_W-1], delta};
        rnd_u  = i_d.prod_u + PU_W'(GAIN_HALF);
        // out of range when the bits above the sign differ from it
        if (nv[NV_W-1:VAL_W-1] == '0 || nv[NV_W-1:VAL_W-1] == '1) begin
            nv_sat = nv[VAL_W-1:0];
        end else if (nv[NV_W-1]) begin
            nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end

        if (i_d.invalid) begin
            n_d.new_value       = i_d.prior_val;
            n_d.new_uncertainty = i_d.prior_unc;
            n_d.invalid         = 1'b1;
        end else begin
            n_d.new_value       = nv_sat;
            n_d.new_uncertainty = rnd_u[VAL_W+GAIN_BITS-1:GAIN_BITS];
            n_d.invalid         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

// File: hw/rtl/scalar_kalman_update.sv
// scalar kalman measurement update, fully pipelined, one beat per clock
// depends on skfu_pkg, skfu_front, skfu_div_step, skfu_mul and skfu_out
//
// Each input beat carries a prior estimate and a measurement, values in
// signed Q16.16 and variances in unsigned Q16.16. The block adds the process
// noise register to the prior variance (saturating), forms the Q0.16 gain
// P/(P+R), and returns the blended value, rounded and saturated, with the
// reduced variance (1-K)P. A zero variance on either input sets the invalid
// flag and returns the prior unchanged. The pipeline takes a new beat every
// clock when the output side does not stall. Its stages are one front stage,
// sixteen restoring divider stages (one gain bit each, the divider sets the
// depth), one multiplier stage and one output register. Results leave in
// order. Back-pressure only stops the stages that are full, so empty slots
// fill up while a result waits. The noise register is written through its
// own port, which is always ready, and should only change while no beat is
// in flight.
`default_nettype none

module scalar_kalman_update
    import skfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire t_in                i_in_data,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output t_out                    o_out_data,
    // process noise register write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [NOISE_W-1:0] i_cfg_data
);

    localparam int LAST = NUM_STG - 1;

    logic [NOISE_W-1:0] r_noise;

    // stage valid bits and load enables, index 0 is the front stage
    logic [LAST:0] vld;
    logic [LAST:0] en;

    t_div div_d [0:GAIN_BITS];
    t_mul mul_d;

    // noise register, reset to 0.01
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= NOISE_RESET;
        end else if (i_cfg_valid) begin
            r_noise <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // a stage loads when it is empty or its content moves on
    assign en[LAST] = !vld[LAST] || i_out_ready;

    for (genvar g = 0; g < LAST; g++) begin : g_en
        assign en[g] = !vld[g] || en[g+1];
    end

    assign o_in_ready = en[0];

    skfu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[0]),
        .i_vld   (i_in_valid),
        .i_item  (i_in_data),
        .i_noise (r_noise),
        .o_vld   (vld[0]),
        .o_d     (div_d[0])
    );

    // divider chain, msb of the gain first
    for (genvar g = 0; g < GAIN_BITS; g++) begin : g_div
        skfu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g+1]),
            .i_vld   (vld[g]),
            .i_d     (div_d[g]),
            .o_vld   (vld[g+1]),
            .o_d     (div_d[g+1])
        );
    end

    skfu_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[GAIN_BITS+1]),
        .i_vld   (vld[GAIN_BITS]),
        .i_d     (div_d[GAIN_BITS]),
        .o_vld   (vld[GAIN_BITS+1]),
        .o_d     (mul_d)
    );

    // final stage doubles as the output register
    skfu_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en[LAST]),
        .i_vld   (vld[GAIN_BITS+1]),
        .i_d     (mul_d),
        .o_vld   (vld[LAST]),
        .o_d     (o_out_data)
    );

    assign o_out_valid = vld[LAST];

endmodule

`default_nettype wire

// File: hw/rtl/skfu_check.sv
// port-level checks for the scalar kalman update, attached by bind
// depends on skfu_pkg and scalar_kalman_update
`default_nettype none

module skfu_check
    import skfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               o_in_ready,
    input  wire t_in                i_in_data,
    input  wire logic               o_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_out               o_out_data
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // a waiting input beat holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat dropped or changed while stalled");

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // draining output means the input side is open
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid || i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    // input back-pressure only after the whole pipe has filled behind a stall
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !$past(o_in_ready) |-> o_out_valid && $past(o_out_valid)
        && !$past(i_out_ready))
        else $error("input stalled without a held result beat");

endmodule

bind scalar_kalman_update skfu_check u_skfu_check (.*);

`default_nettype wire

// File: tb/sv/skfu_update_checker.sv
// result checker for the scalar kalman update block: predicts each beat and compares
// depends on skfu_pkg for the beat types, widths and the noise reset value

module skfu_update_checker
    import skfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire t_in                i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_out               i_out_data,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [NOISE_W-1:0] i_cfg_data,
    output int                      o_pending,
    output int                      o_mismatches
);

    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;

    logic [NOISE_W-1:0] noise_level;
    t_out               expected_updates[$];
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // measurement update of one beat under the given process noise
    function automatic t_out kalman_blend(input t_in item, input logic [NOISE_W-1:0] noise);
        t_out              res;
        longint unsigned   var_sum;
        longint unsigned   gain;
        longint unsigned   shrunk;
        longint            x_val;
        longint            z_val;
        longint            delta;
        longint            blended;
        if (item.prior_uncertainty == '0 || item.measured_uncertainty == '0) begin
            res.new_value       = item.prior_value;
            res.new_uncertainty = item.prior_uncertainty;
            res.invalid         = 1'b1;
            return res;
        end
        var_sum = 64'(item.prior_uncertainty) + 64'(noise);
        if (var_sum > 64'hFFFF_FFFF) begin
            var_sum = 64'hFFFF_FFFF;
        end
        gain = (var_sum << GAIN_BITS) / (var_sum + 64'(item.measured_uncertainty));
        x_val = $signed(item.prior_value);
        z_val = $signed(item.measured_value);
        // floor of the rounded product, ties towards plus infinity
        delta = (longint'(gain) * (z_val - x_val) + longint'(GAIN_HALF)) >>> GAIN_BITS;
        blended = x_val + delta;
        if (blended > VAL_MAX) begin
            blended = VAL_MAX;
        end
        if (blended < VAL_MIN) begin
            blended = VAL_MIN;
        end
        shrunk = ((64'(GAIN_ONE) - gain) * var_sum + 64'(GAIN_HALF)) >> GAIN_BITS;
        res.new_value       = blended[VAL_W-1:0];
        res.new_uncertainty = shrunk[VAL_W-1:0];
        res.invalid         = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            noise_level = NOISE_RESET;
            expected_updates.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                noise_level = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                expected_updates.push_back(kalman_blend(i_in_data, noise_level));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_updates.size() == 0) begin
                    report_mismatch("result beat with no update outstanding");
                end else begin
                    want = expected_updates.pop_front();
                    if (i_out_data.new_value !== want.new_value) begin
                        report_mismatch($sformatf("new_value got %0d expected %0d",
                            $signed(i_out_data.new_value), $signed(want.new_value)));
                    end
                    if (i_out_data.new_uncertainty !== want.new_uncertainty) begin
                        report_mismatch($sformatf("new_uncertainty got %0d expected %0d",
                            i_out_data.new_uncertainty, want.new_uncertainty));
                    end
                    if (i_out_data.invalid !== want.invalid) begin
                        report_mismatch($sformatf("invalid got %b expected %b",
                            i_out_data.invalid, want.invalid));
                    end
                end
            end
        end
        o_pending = expected_updates.size();
    end

endmodule

// File: tb/sv/scalar_kalman_update_tb.sv
// top of the scalar kalman update testbench: clock, reset, stimulus and verdict
// depends on skfu_pkg, the scalar_kalman_update block and skfu_update_checker

module scalar_kalman_update_tb
    import skfu_pkg::*;
;

    // cycles without any accepted beat before the run is declared hung;
    // the worst honest stretch is a result stall plus the pipeline depth
    localparam int HANG_LIMIT  = 4000;
    localparam int PHASE_BEATS = 230;
    localparam int NUM_PHASES  = 5;
    localparam logic [VAL_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [VAL_W-1:0] VAL_TOP = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_BOT = 32'h8000_0000;
    localparam logic [VAL_W-1:0] VAR_TOP = 32'hFFFF_FFFF;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    t_in                in_data;
    logic               out_valid;
    logic               out_ready;
    t_out               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [NOISE_W-1:0] cfg_data;
    int                 pending;
    int                 mismatches;
    int                 hang_cycles;
    // set for the closing phase, which runs with no idling on either side
    logic               quiet;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    scalar_kalman_update DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    skfu_update_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    // watchdog: any accepted beat on any channel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            hang_cycles <= 0;
        end else if (hang_cycles >= HANG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            hang_cycles <= hang_cycles + 1;
        end
    end

    // result side back-pressure: occasional stall bursts
    initial begin
        out_ready = 1'b0;
        @(posedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic t_in pack_update(input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] p,
                                        input logic [VAL_W-1:0] z, input logic [VAL_W-1:0] r);
        t_in item;
        item.prior_value          = x;
        item.prior_uncertainty    = p;
        item.measured_value       = z;
        item.measured_uncertainty = r;
        return item;
    endfunction

    // mostly plausible estimates with a nearby measurement, some raw noise,
    // and the odd zero variance to hit the invalid path
    function automatic t_in random_update();
        t_in         item;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            item = pack_update($urandom, $urandom, $urandom, $urandom);
        end else begin
            item.prior_value          = $signed($urandom) >>> $urandom_range(0, 24);
            item.measured_value       = item.prior_value
                                        + ($signed($urandom) >>> $urandom_range(2, 28));
            item.prior_uncertainty    = $urandom >> $urandom_range(0, 31);
            item.measured_uncertainty = $urandom >> $urandom_range(0, 31);
        end
        if (pick % 25 == 3) begin
            item.prior_uncertainty = '0;
        end
        if (pick % 25 == 7) begin
            item.measured_uncertainty = '0;
        end
        return item;
    endfunction

    // present one beat and hold it until taken; valid stays high afterwards
    task automatic send_update(input t_in item);
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold the sender off until every outstanding update has come back;
    // the count is sampled at the falling edge, after the checker has settled
    task automatic wait_all_returned();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_noise(input logic [NOISE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        quiet     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset noise level
        send_update(pack_update(Q_ONE, Q_ONE, 32'h0002_0000, Q_ONE));
        send_update(pack_update(32'hFFFC_8000, 32'h0000_4000, 32'h0007_0000, 32'h0004_0000));
        maybe_pause();
        // zero variance on one side, the other, and both with extreme values
        send_update(pack_update(32'h0005_0000, '0, Q_ONE, Q_ONE));
        send_update(pack_update(32'h0005_0000, 32'h0002_0000, Q_ONE, '0));
        send_update(pack_update(VAL_BOT, '0, VAL_TOP, '0));
        send_update(pack_update(VAL_TOP, '0, VAL_BOT, VAR_TOP));
        // prior variance plus noise saturates, gain close to one
        send_update(pack_update(VAL_BOT, VAR_TOP, VAL_TOP, 32'h0000_0001));
        // gain close to zero
        send_update(pack_update(VAL_TOP, 32'h0000_0001, VAL_BOT, VAR_TOP));
        send_update(pack_update(VAL_TOP, VAR_TOP, VAL_BOT, VAR_TOP));
        send_update(pack_update('0, 32'h0000_0001, '0, 32'h0000_0001));
        send_update(pack_update(32'hFFFF_FFFF, VAR_TOP, 32'h0000_0001, VAR_TOP));
        maybe_pause();
        send_update(pack_update(32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFE, 32'h0000_0001));
        send_update(pack_update(VAL_TOP, VAR_TOP - 32'd100, VAL_TOP, 32'h0000_0005));
        send_update(pack_update(32'h8000_0001, 32'h0000_0001, 32'h7FFF_FFFE, 32'h0000_0002));
        // half gain with an odd difference: rounding ties of either sign
        send_update(pack_update('0, 32'h0000_0001, 32'h0000_0001, 32'd656));
        send_update(pack_update('0, 32'h0000_0001, 32'hFFFF_FFFF, 32'd656));
        send_update(pack_update(32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFE, 32'd656));

        // random phases, each under its own noise level, written while idle
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_all_returned();
            case (phase)
                0: write_noise('0);
                1: write_noise('1);
                2: write_noise(NOISE_W'($urandom));
                3: write_noise(NOISE_W'($urandom_range(0, 65535)));
                default: write_noise(NOISE_RESET);
            endcase
            quiet <= (phase == NUM_PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                // mid-phase hold-off until the pipeline has fully drained
                if (phase == 2 && n == PHASE_BEATS / 2) begin
                    wait_all_returned();
                end
                send_update(random_update());
                maybe_pause();
            end
        end

        wait_all_returned();
        repeat (2 * NUM_STG) @(posedge clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/skfu_pkg.sv
hw/rtl/skfu_front.sv
hw/rtl/skfu_div_step.sv
hw/rtl/skfu_mul.sv
hw/rtl/skfu_out.sv
hw/rtl/scalar_kalman_update.sv
hw/rtl/skfu_check.sv
tb/sv/skfu_update_checker.sv
tb/sv/scalar_kalman_update_tb.sv
